>>> design/svptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svptw_pkg: shared types and codes for the Sv39 page table walker
// Beat layouts, walk state, configuration registers and encodings.
// ----------------------------------------------------------------------------
package svptw_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TRANSLATION_MODE = 3'd0;
    localparam logic [2:0] REG_ROOT_TABLE_PPN   = 3'd1;
    localparam logic [2:0] REG_PRIVILEGE_MODE   = 3'd2;
    localparam logic [2:0] REG_SUM              = 3'd3;
    localparam logic [2:0] REG_MXR              = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 44;

    // Command codes
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_ENTRY     = 1'b1;

    // Result kinds
    localparam logic RES_READ_REQ = 1'b0;
    localparam logic RES_DONE     = 1'b1;

    // Access kinds
    localparam logic [1:0] ACC_LOAD  = 2'd0;
    localparam logic [1:0] ACC_STORE = 2'd1;
    localparam logic [1:0] ACC_FETCH = 2'd2;
    localparam logic [1:0] ACC_RSVD  = 2'd3;

    // Privilege levels
    localparam logic [1:0] PRIV_USER  = 2'd0;
    localparam logic [1:0] PRIV_SUPER = 2'd1;
    localparam logic [1:0] PRIV_MACH  = 2'd3;

    // satp modes
    localparam logic [3:0] MODE_BARE = 4'd0;
    localparam logic [3:0] MODE_SV39 = 4'd8;

    localparam logic [1:0] STATUS_OK = 2'd0;

    localparam logic [1:0] LEVEL_ROOT = 2'd2;

    typedef struct packed {
        logic        command;
        logic [63:0] vaddr;
        logic [1:0]  access_kind;
        logic [63:0] entry_word;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [55:0] entry_address;
        logic [63:0] paddr;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic        active;
        logic [1:0]  level;
        logic [43:0] table_page;
        logic [26:0] page_numbers;
        logic [11:0] page_offset;
        logic [1:0]  access_kind;
    } walk_t;

    typedef struct packed {
        logic [3:0]  translation_mode;
        logic [43:0] root_table_ppn;
        logic [1:0]  privilege_mode;
        logic        sum;
        logic        mxr;
    } cfg_t;

endpackage

>>> design/svptw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svptw_step: one walk step
// Takes a registered beat and the walk state, and gives the next walk state
// and at most one result beat. Purely combinational.
// ----------------------------------------------------------------------------
module svptw_step
(
    input  svptw_pkg::item_t   item,
    input  svptw_pkg::walk_t   walk,
    input  svptw_pkg::cfg_t    cfg,
    output svptw_pkg::walk_t   walk_next,
    output logic               emit,
    output svptw_pkg::result_t result
);
    import svptw_pkg::*;

    logic [1:0]  start_kind;
    logic [1:0]  new_level;
    logic [8:0]  vpn_new;
    logic [43:0] pte_ppn;
    logic [25:0] ppn2;
    logic [8:0]  ppn1;
    logic [8:0]  ppn0;
    logic [8:0]  pa_ppn1;
    logic [8:0]  pa_ppn0;
    logic        pte_d, pte_a, pte_u, pte_x, pte_w, pte_r, pte_v;
    logic        bad_format;
    logic        is_pointer;
    logic        leaf_fault;
    logic        canonical;

    // Entry fields
    assign pte_ppn = item.entry_word[53:10];
    assign ppn2    = item.entry_word[53:28];
    assign ppn1    = item.entry_word[27:19];
    assign ppn0    = item.entry_word[18:10];
    assign pte_d   = item.entry_word[7];
    assign pte_a   = item.entry_word[6];
    assign pte_u   = item.entry_word[4];
    assign pte_x   = item.entry_word[3];
    assign pte_w   = item.entry_word[2];
    assign pte_r   = item.entry_word[1];
    assign pte_v   = item.entry_word[0];

    assign start_kind = (item.access_kind == ACC_RSVD) ? ACC_LOAD : item.access_kind;
    assign canonical  = (item.vaddr[63:38] == '0)
                     || (item.vaddr[63:38] == '1);
    assign new_level  = walk.level - 2'd1;

    // VPN slice for the level below
    always_comb
    begin
        case (new_level)
            2'd0:    vpn_new = walk.page_numbers[8:0];
            2'd1:    vpn_new = walk.page_numbers[17:9];
            2'd2:    vpn_new = walk.page_numbers[26:18];
            default: vpn_new = '0;
        endcase
    end

    // Entry checks
    assign bad_format = (item.entry_word[63:54] != '0) || !pte_v || (pte_w && !pte_r);
    assign is_pointer = !pte_r && !pte_x;

    always_comb
    begin
        leaf_fault = 1'b0;
        if ((walk.level == 2'd2) && ((ppn1 != '0) || (ppn0 != '0)))
            leaf_fault = 1'b1;
        if ((walk.level == 2'd1) && (ppn0 != '0))
            leaf_fault = 1'b1;
        if ((cfg.privilege_mode == PRIV_USER) && !pte_u)
            leaf_fault = 1'b1;
        if ((cfg.privilege_mode == PRIV_SUPER) && pte_u
            && ((walk.access_kind == ACC_FETCH) || !cfg.sum))
            leaf_fault = 1'b1;
        if ((walk.access_kind == ACC_STORE) && !pte_w)
            leaf_fault = 1'b1;
        if ((walk.access_kind == ACC_LOAD) && !pte_r && !(cfg.mxr && pte_x))
            leaf_fault = 1'b1;
        if ((walk.access_kind == ACC_FETCH) && !pte_x)
            leaf_fault = 1'b1;
        if (!pte_a || ((walk.access_kind == ACC_STORE) && !pte_d))
            leaf_fault = 1'b1;
    end

    // Superpages take the low page numbers from the virtual address
    assign pa_ppn1 = (walk.level == 2'd2) ? walk.page_numbers[17:9] : ppn1;
    assign pa_ppn0 = (walk.level != 2'd0) ? walk.page_numbers[8:0]  : ppn0;

    // Step decision
    always_comb
    begin
        walk_next = walk;
        emit      = 1'b0;
        result    = '0;
        if (item.command == CMD_TRANSLATE)
        begin
            walk_next.active = 1'b0;
            emit             = 1'b1;
            result.result_kind = RES_DONE;
            if ((cfg.translation_mode == MODE_BARE) || (cfg.privilege_mode == PRIV_MACH))
                result.paddr = item.vaddr;
            else if ((cfg.translation_mode != MODE_SV39) || !canonical)
                result.status = start_kind + 2'd1;
            else
            begin
                walk_next.active       = 1'b1;
                walk_next.level        = LEVEL_ROOT;
                walk_next.table_page   = cfg.root_table_ppn;
                walk_next.page_numbers = item.vaddr[38:12];
                walk_next.page_offset  = item.vaddr[11:0];
                walk_next.access_kind  = start_kind;
                result.result_kind     = RES_READ_REQ;
                result.entry_address   = {cfg.root_table_ppn,
                                          item.vaddr[38:30], 3'b000};
            end
        end
        else if (walk.active)
        begin
            emit               = 1'b1;
            result.result_kind = RES_DONE;
            walk_next.active   = 1'b0;
            if (bad_format || (is_pointer && (walk.level == 2'd0)))
                result.status = walk.access_kind + 2'd1;
            else if (is_pointer)
            begin
                walk_next.active     = 1'b1;
                walk_next.table_page = pte_ppn;
                walk_next.level      = new_level;
                result.result_kind   = RES_READ_REQ;
                result.entry_address = {pte_ppn, vpn_new, 3'b000};
            end
            else if (leaf_fault)
                result.status = walk.access_kind + 2'd1;
            else
                result.paddr = {8'h00, ppn2, pa_ppn1, pa_ppn0,
                                walk.page_offset};
        end
    end

endmodule

>>> design/sv39_page_table_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_table_walker: Sv39 three-level page table walker
// Translate commands and returned entries come in as beats; read requests
// and finished translations go out. Entry memory is outside the block.
// ----------------------------------------------------------------------------
// Path: a taken beat goes into the input register, is checked by the step logic
//   and its result is registered in the result register, which drives out_valid.
// Throughput: one beat per cycle; the result register frees itself in the
//   same cycle it is taken, so the input side only stalls on output stall.
// Reset: idle walker, level 2, all config zero except privilege (machine).
// ----------------------------------------------------------------------------
module sv39_page_table_walker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [63:0]                        vaddr,
    input  logic [1:0]                         access_kind,
    input  logic [63:0]                        entry_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               result_kind,
    output logic [55:0]                        entry_address,
    output logic [63:0]                        paddr,
    output logic [1:0]                         status,
    input  logic                               cfg_write,
    input  logic [svptw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [svptw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import svptw_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg;
    walk_t   walk_reg;
    walk_t   walk_next;
    cfg_t    cfg_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    emit;
    logic    advance;
    logic    in_take;

    // Pipeline flow
    assign advance  = !result_valid_reg || !out_stall;
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    svptw_step u_step
    (
        .item      (item_reg),
        .walk      (walk_reg),
        .cfg       (cfg_reg),
        .walk_next (walk_next),
        .emit      (emit),
        .result    (result_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_take)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.command     <= command;
            item_reg.vaddr       <= vaddr;
            item_reg.access_kind <= access_kind;
            item_reg.entry_word  <= entry_word;
        end
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg.active       <= 1'b0;
            walk_reg.level        <= LEVEL_ROOT;
            walk_reg.table_page   <= '0;
            walk_reg.page_numbers <= '0;
            walk_reg.page_offset  <= '0;
            walk_reg.access_kind  <= ACC_LOAD;
        end
        else if (item_valid_reg && advance)
            walk_reg <= walk_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= item_valid_reg && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg && emit)
            result_reg <= result_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.translation_mode <= MODE_BARE;
            cfg_reg.root_table_ppn   <= '0;
            cfg_reg.privilege_mode   <= PRIV_MACH;
            cfg_reg.sum              <= 1'b0;
            cfg_reg.mxr              <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TRANSLATION_MODE: cfg_reg.translation_mode <= cfg_data[3:0];
                REG_ROOT_TABLE_PPN:   cfg_reg.root_table_ppn   <= cfg_data[43:0];
                REG_PRIVILEGE_MODE:   cfg_reg.privilege_mode   <= cfg_data[1:0];
                REG_SUM:              cfg_reg.sum              <= cfg_data[0];
                REG_MXR:              cfg_reg.mxr              <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Outputs
    assign out_valid     = result_valid_reg;
    assign result_kind   = result_reg.result_kind;
    assign entry_address = result_reg.entry_address;
    assign paddr         = result_reg.paddr;
    assign status        = result_reg.status;

endmodule
